[sv/apint_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apint_pkg
// Shared types, constants and the arctangent table of the pose integrator.
// ----------------------------------------------------------------------------
package apint_pkg;

  localparam int FracBits   = 20;
  localparam int AtanFrac   = 30;
  localparam int CordicIter = 30;
  localparam int SqrtIter   = 32;
  localparam int DivW       = 32 + FracBits;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SCALE_ERR = 2'd1,
    ST_ANGLE_ERR = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_AD,
    OP_MUL_BC,
    OP_DET,
    OP_SQ_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_HEIGHT,
    OP_MUL_SS,
    OP_MUL_CC,
    OP_SQ_COS,
    OP_CORDIC_INIT,
    OP_CORDIC_STEP,
    OP_ANGLE,
    OP_ACC_X,
    OP_ACC_Y,
    OP_EMIT
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_MAD, S_MBC, S_DET, S_SQ1, S_DIVI, S_DIV, S_HGT, S_MSS, S_MCC,
    S_SQ2I, S_SQ2, S_CRI, S_CR, S_ANG, S_ACX, S_ACY, S_EMIT
  } state_e;

  typedef struct packed {
    logic det_bad;
    logic c_big;
    logic last;
    logic out_busy;
  } stat_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd843314856;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043836;
      5'd3:  v = 32'd133525158;
      5'd4:  v = 32'd67021686;
      5'd5:  v = 32'd33543515;
      5'd6:  v = 32'd16775850;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194282;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048575;
      5'd11: v = 32'd524287;
      5'd12: v = 32'd262143;
      5'd13: v = 32'd131071;
      5'd14: v = 32'd65535;
      5'd15: v = 32'd32767;
      5'd16: v = 32'd16383;
      5'd17: v = 32'd8191;
      5'd18: v = 32'd4095;
      5'd19: v = 32'd2047;
      5'd20: v = 32'd1023;
      5'd21: v = 32'd511;
      5'd22: v = 32'd255;
      5'd23: v = 32'd127;
      5'd24: v = 32'd63;
      5'd25: v = 32'd31;
      5'd26: v = 32'd15;
      5'd27: v = 32'd8;
      5'd28: v = 32'd4;
      5'd29: v = 32'd2;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

[sv/apint_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apint_ctrl
// Sequencer: steps the datapath through one transform update.
// ----------------------------------------------------------------------------
module apint_ctrl import apint_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output op_e   op_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_MAD;
      S_MAD:  state_d = S_MBC;
      S_MBC:  state_d = S_DET;
      S_DET:  state_d = stat_i.det_bad ? S_EMIT : S_SQ1;
      S_SQ1:  if (stat_i.last) state_d = S_DIVI;
      S_DIVI: state_d = S_DIV;
      S_DIV:  if (stat_i.last) state_d = S_HGT;
      S_HGT:  state_d = stat_i.c_big ? S_EMIT : S_MSS;
      S_MSS:  state_d = S_MCC;
      S_MCC:  state_d = S_SQ2I;
      S_SQ2I: state_d = S_SQ2;
      S_SQ2:  if (stat_i.last) state_d = S_CRI;
      S_CRI:  state_d = S_CR;
      S_CR:   if (stat_i.last) state_d = S_ANG;
      S_ANG:  state_d = S_ACX;
      S_ACX:  state_d = S_ACY;
      S_ACY:  state_d = S_EMIT;
      S_EMIT: if (!stat_i.out_busy) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_o       = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = OP_LOAD;
      end
      S_MAD:  op_o = OP_MUL_AD;
      S_MBC:  op_o = OP_MUL_BC;
      S_DET:  op_o = OP_DET;
      S_SQ1:  op_o = OP_SQ_STEP;
      S_DIVI: op_o = OP_DIV_INIT;
      S_DIV:  op_o = OP_DIV_STEP;
      S_HGT:  op_o = OP_HEIGHT;
      S_MSS:  op_o = OP_MUL_SS;
      S_MCC:  op_o = OP_MUL_CC;
      S_SQ2I: op_o = OP_SQ_COS;
      S_SQ2:  op_o = OP_SQ_STEP;
      S_CRI:  op_o = OP_CORDIC_INIT;
      S_CR:   op_o = OP_CORDIC_STEP;
      S_ANG:  op_o = OP_ANGLE;
      S_ACX:  op_o = OP_ACC_X;
      S_ACY:  op_o = OP_ACC_Y;
      S_EMIT: if (!stat_i.out_busy) op_o = OP_EMIT;
      default: op_o = OP_NONE;
    endcase
  end

endmodule

[sv/apint_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apint_dp
// Datapath: shared multiplier, square root, divider, CORDIC and pose state.
// ----------------------------------------------------------------------------
module apint_dp import apint_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  op_e                op_i,
  output stat_t              stat_o,
  input  logic signed [31:0] coef_a_i,
  input  logic signed [31:0] coef_b_i,
  input  logic signed [31:0] shift_x_i,
  input  logic signed [31:0] coef_c_i,
  input  logic signed [31:0] coef_d_i,
  input  logic signed [31:0] shift_y_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [1:0]         status_o,
  output logic signed [47:0] pos_x_o,
  output logic signed [47:0] pos_y_o,
  output logic signed [39:0] heading_o,
  output logic [31:0]        altitude_o
);

  logic signed [31:0] a_q, b_q, c_q, d_q, sx_q, sy_q;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;
  logic signed [63:0] ad_q;
  logic [63:0]        sq_n_q;
  logic [32:0]        sq_rem_q;
  logic [31:0]        root_q;
  logic [DivW-1:0]    dv_num_q, dv_quo_q;
  logic [31:0]        dv_rem_q;
  logic signed [35:0] cx_q, cy_q;
  logic signed [32:0] cz_q;
  logic [5:0]         cnt_q;
  logic signed [47:0] x_q, y_q;
  logic signed [39:0] ang_q;
  logic [31:0]        hgt_q;
  status_e            status_q;
  logic               out_valid_q;
  logic [1:0]         ost_q;
  logic signed [47:0] ox_q, oy_q;
  logic signed [39:0] oang_q;
  logic [31:0]        ohgt_q;

  logic [31:0]        cmag;
  logic signed [64:0] det_diff;
  logic [34:0]        sq_sh, sq_trial;
  logic               sq_ge;
  logic [32:0]        dv_sh;
  logic               dv_ge;
  logic signed [35:0] cxs, cys;
  logic signed [32:0] z_rnd, z_ang;
  logic signed [40:0] ang_sum;
  logic signed [65:0] inc;
  logic signed [48:0] x_sum, y_sum;
  logic               last;

  assign cmag     = c_q[31] ? (~c_q + 32'd1) : c_q;
  assign det_diff = {ad_q[63], ad_q} - {prod_q[63], prod_q[63:0]};
  assign sq_sh    = {sq_rem_q, sq_n_q[63:62]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;
  assign dv_sh    = {dv_rem_q, dv_num_q[DivW-1]};
  assign dv_ge    = dv_sh >= {1'b0, root_q};
  assign cxs      = cx_q >>> cnt_q;
  assign cys      = cy_q >>> cnt_q;
  assign z_rnd    = cz_q + (33'sd1 <<< (AtanFrac - FracBits - 1));
  assign z_ang    = z_rnd >>> (AtanFrac - FracBits);
  assign ang_sum  = {ang_q[39], ang_q} + {{8{z_ang[32]}}, z_ang};
  assign inc      = prod_q >>> FracBits;
  assign x_sum    = {x_q[47], x_q} + inc[48:0];
  assign y_sum    = {y_q[47], y_q} + inc[48:0];

  always_comb begin
    case (op_i)
      OP_SQ_STEP:     last = cnt_q == 6'(SqrtIter - 1);
      OP_DIV_STEP:    last = cnt_q == 6'(DivW - 1);
      OP_CORDIC_STEP: last = cnt_q == 6'(CordicIter - 1);
      default:        last = 1'b0;
    endcase
  end

  assign stat_o.det_bad  = det_diff[64] | (det_diff == 65'sd0);
  assign stat_o.c_big    = cmag > root_q;
  assign stat_o.last     = last;
  assign stat_o.out_busy = out_valid_q & ~out_ready_i;

  always_comb begin
    case (op_i)
      OP_MUL_BC: begin
        mul_a = {b_q[31], b_q};
        mul_b = {c_q[31], c_q};
      end
      OP_MUL_SS: begin
        mul_a = {1'b0, root_q};
        mul_b = {1'b0, root_q};
      end
      OP_MUL_CC: begin
        mul_a = {1'b0, cmag};
        mul_b = {1'b0, cmag};
      end
      OP_ANGLE: begin
        mul_a = {sx_q[31], sx_q};
        mul_b = {1'b0, hgt_q};
      end
      OP_ACC_X: begin
        mul_a = {sy_q[31], sy_q};
        mul_b = {1'b0, hgt_q};
      end
      default: begin
        mul_a = {a_q[31], a_q};
        mul_b = {d_q[31], d_q};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (op_i)
      OP_LOAD: begin
        a_q  <= coef_a_i;
        b_q  <= coef_b_i;
        c_q  <= coef_c_i;
        d_q  <= coef_d_i;
        sx_q <= shift_x_i;
        sy_q <= shift_y_i;
      end
      OP_MUL_BC, OP_MUL_CC: ad_q <= prod_q[63:0];
      OP_DET: begin
        sq_n_q   <= det_diff[63:0];
        sq_rem_q <= '0;
        root_q   <= '0;
      end
      OP_SQ_COS: begin
        sq_n_q   <= ad_q - prod_q[63:0];
        sq_rem_q <= '0;
        root_q   <= '0;
      end
      OP_SQ_STEP: begin
        sq_rem_q <= sq_ge ? 33'(sq_sh - sq_trial) : sq_sh[32:0];
        root_q   <= {root_q[30:0], sq_ge};
        sq_n_q   <= {sq_n_q[61:0], 2'b00};
      end
      OP_DIV_INIT: begin
        dv_num_q <= {hgt_q, {FracBits{1'b0}}};
        dv_rem_q <= '0;
        dv_quo_q <= '0;
      end
      OP_DIV_STEP: begin
        dv_rem_q <= dv_ge ? 32'(dv_sh - {1'b0, root_q}) : dv_sh[31:0];
        dv_quo_q <= {dv_quo_q[DivW-2:0], dv_ge};
        dv_num_q <= {dv_num_q[DivW-2:0], 1'b0};
      end
      OP_CORDIC_INIT: begin
        cx_q <= {4'b0000, root_q};
        cy_q <= {{4{c_q[31]}}, c_q};
        cz_q <= '0;
      end
      OP_CORDIC_STEP: begin
        if (!cy_q[35]) begin
          cx_q <= cx_q + cys;
          cy_q <= cy_q - cxs;
          cz_q <= cz_q + {1'b0, atan_entry(cnt_q[4:0])};
        end else begin
          cx_q <= cx_q - cys;
          cy_q <= cy_q + cxs;
          cz_q <= cz_q - {1'b0, atan_entry(cnt_q[4:0])};
        end
      end
      default: ;
    endcase
    if (op_i == OP_EMIT) begin
      ost_q  <= status_q;
      ox_q   <= x_q;
      oy_q   <= y_q;
      oang_q <= ang_q;
      ohgt_q <= hgt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      ang_q       <= '0;
      hgt_q       <= 32'd1 << FracBits;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      case (op_i)
        OP_DET: begin
          cnt_q    <= '0;
          status_q <= stat_o.det_bad ? ST_SCALE_ERR : ST_OK;
        end
        OP_SQ_COS, OP_DIV_INIT, OP_CORDIC_INIT: cnt_q <= '0;
        OP_SQ_STEP, OP_DIV_STEP, OP_CORDIC_STEP: cnt_q <= cnt_q + 6'd1;
        OP_HEIGHT: begin
          hgt_q <= (|dv_quo_q[DivW-1:32]) ? '1 : dv_quo_q[31:0];
          if (stat_o.c_big) status_q <= ST_ANGLE_ERR;
        end
        OP_ANGLE: begin
          if (ang_sum[40] != ang_sum[39]) begin
            ang_q <= ang_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
          end else begin
            ang_q <= ang_sum[39:0];
          end
        end
        OP_ACC_X: begin
          if (x_sum[48] != x_sum[47]) begin
            x_q <= x_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
          end else begin
            x_q <= x_sum[47:0];
          end
        end
        OP_ACC_Y: begin
          if (y_sum[48] != y_sum[47]) begin
            y_q <= y_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
          end else begin
            y_q <= y_sum[47:0];
          end
        end
        default: ;
      endcase
      if (op_i == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = ost_q;
  assign pos_x_o     = ox_q;
  assign pos_y_o     = oy_q;
  assign heading_o   = oang_q;
  assign altitude_o  = ohgt_q;

endmodule

[sv/affine_pose_integrator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_pose_integrator
// Dead-reckoned pose (x, y, heading, height) from 2x3 similarity transforms.
// ----------------------------------------------------------------------------
// One word in, one word out. A word ends early when the determinant is
// not positive or on an angle error; the full update runs two 32-step
// square roots, a 52-step restoring divide and 30 CORDIC steps, all one
// step per cycle, plus steps on the shared 33x33 multiplier. A new word
// is taken as soon as the previous result sits in the output register.
module affine_pose_integrator import apint_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] coef_a_i,
  input  logic signed [31:0] coef_b_i,
  input  logic signed [31:0] shift_x_i,
  input  logic signed [31:0] coef_c_i,
  input  logic signed [31:0] coef_d_i,
  input  logic signed [31:0] shift_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [47:0] pos_x_o,
  output logic signed [47:0] pos_y_o,
  output logic signed [39:0] heading_o,
  output logic [31:0]        altitude_o
);

  op_e   op;
  stat_t stat;

  apint_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .op_o       (op)
  );

  apint_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .stat_o      (stat),
    .coef_a_i    (coef_a_i),
    .coef_b_i    (coef_b_i),
    .shift_x_i   (shift_x_i),
    .coef_c_i    (coef_c_i),
    .coef_d_i    (coef_d_i),
    .shift_y_i   (shift_y_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .heading_o   (heading_o),
    .altitude_o  (altitude_o)
  );

endmodule
